FILE: sv/deque_min_max_average_top_defines.svh
// assertion macros for the deque block
// each expects clk and rst_n in the scope where it is used
`ifndef DEQUE_MIN_MAX_AVERAGE_TOP_DEFINES_SVH
`define DEQUE_MIN_MAX_AVERAGE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DMMA_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("deque assertion failed");
`define DMMA_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("deque assertion failed");
`else
`define DMMA_ASSERT_IMP(lbl, a, c)
`define DMMA_ASSERT_NXT(lbl, a, c)
`endif

`endif

FILE: sv/dmma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dmma_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_REM_FRONT = 3'd2,
    ACT_REM_BACK  = 3'd3,
    ACT_REVERSE   = 3'd4,
    ACT_QUERY     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

FILE: sv/deque_min_max_average_top.sv
// double-ended store of signed fixed-point values with min, max and average query
// input channel: in_tuser carries the action, in_tdata the value to insert
// output channel: one word per input word; out_tuser carries the status,
// out_tdata the count after the action and the query results
// in_tready is high only while the sequencer is idle; one item is worked at a time
// insert, remove and reverse: the action is done on acceptance, the sequencer moves to
// S_FIN, loads the result word into the output register and returns to S_IDLE
// query: S_SCAN walks the ring through the single memory read port and sums the entries,
// S_DIV divides the sum by the count in the divider, and S_FIN loads the result word
// into the output register
// at reset the store is empty and out_tvalid is low; the entry memory is not
// cleared, only occupied entries are ever read
// when the receiver stalls, the result word holds in the output register and the
// block still accepts and works the next item, then waits until the register frees
`timescale 1ns / 1ps
`default_nettype none
`include "deque_min_max_average_top_defines.svh"
module deque_min_max_average_top
  import dmma_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int VW     = VALUE_WIDTH,
  localparam int CW     = $clog2(DEPTH + 1),
  localparam int IN_DW  = ((VW + 7) / 8) * 8,
  localparam int OUT_DW = ((CW + 3 * VW + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // value
  input  wire logic [2:0]        in_tuser,   // action
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_DW-1:0] out_tdata,  // count, maximum, minimum, average
  output logic      [1:0]        out_tuser   // status
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = VW + CW;

  state_t        state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rev_r, rev_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          first_r, first_nxt;
  logic [VW-1:0] max_r, max_nxt;
  logic [VW-1:0] min_r, min_nxt;
  logic [VW-1:0] avg_r, avg_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic          neg_r, neg_nxt;
  status_t       st_r, st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]    out_tuser_r, out_tuser_nxt;

  logic          in_acc;
  action_t       act;
  logic [VW-1:0] in_val;
  logic          low_side;
  logic [AW+1:0] high_sum;
  logic [AW-1:0] high_addr;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] ptr_inc;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [VW-1:0] rd_data;
  logic [SW-1:0] rd_ext;

  logic          div_start;
  logic [SW-1:0] div_mag;
  logic          div_done;
  logic [SW-1:0] div_quo;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign act       = action_t'(in_tuser);
  assign in_val    = in_tdata[VW-1:0];

  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign ptr_inc   = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  assign high_sum  = (AW + 2)'(front_r) + (AW + 2)'(cnt_r);
  assign high_addr = (high_sum >= (AW + 2)'(DEPTH)) ? AW'(high_sum - (AW + 2)'(DEPTH))
                                                    : AW'(high_sum);
  assign rd_ext    = {{CW{rd_data[VW-1]}}, rd_data};
  assign div_mag   = sum_r[SW-1] ? SW'(-sum_r) : sum_r;

  dmma_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_val),
    .raddr (ptr_r),
    .rdata (rd_data)
  );

  dmma_div #(
    .N (SW),
    .D (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      cnt_r       <= '0;
      rev_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      cnt_r       <= cnt_nxt;
      rev_r       <= rev_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    iss_r       <= iss_nxt;
    first_r     <= first_nxt;
    max_r       <= max_nxt;
    min_r       <= min_nxt;
    avg_r       <= avg_nxt;
    sum_r       <= sum_nxt;
    neg_r       <= neg_nxt;
    st_r        <= st_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    cnt_nxt       = cnt_r;
    rev_nxt       = rev_r;
    ptr_nxt       = ptr_r;
    iss_nxt       = iss_r;
    rd_vld_nxt    = 1'b0;
    first_nxt     = first_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    avg_nxt       = avg_r;
    sum_nxt       = sum_r;
    neg_nxt       = neg_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    mem_we        = 1'b0;
    mem_waddr     = high_addr;
    low_side      = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt    = ST_OK;
          max_nxt   = '0;
          min_nxt   = '0;
          avg_nxt   = '0;
          state_nxt = S_FIN;
          case (act) inside
            ACT_INS_FRONT, ACT_INS_BACK: begin
              low_side = (act == ACT_INS_FRONT) != rev_r;
              if (cnt_r == CW'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                if (low_side) begin
                  mem_waddr = front_dec;
                  front_nxt = front_dec;
                end
              end
            end
            ACT_REM_FRONT, ACT_REM_BACK: begin
              low_side = (act == ACT_REM_FRONT) != rev_r;
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
                if (low_side) begin
                  front_nxt = front_inc;
                end
              end
            end
            ACT_REVERSE: begin
              rev_nxt = !rev_r;
            end
            ACT_QUERY: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                ptr_nxt   = front_r;
                iss_nxt   = '0;
                first_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // one read issued per cycle, data comes back from the registered read port in the next cycle
        if (iss_r != cnt_r) begin
          ptr_nxt    = ptr_inc;
          iss_nxt    = iss_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          first_nxt = 1'b0;
          if (first_r) begin
            max_nxt = rd_data;
            min_nxt = rd_data;
            sum_nxt = rd_ext;
          end else begin
            if ($signed(rd_data) > $signed(max_r)) max_nxt = rd_data;
            if ($signed(rd_data) < $signed(min_r)) min_nxt = rd_data;
            sum_nxt = sum_r + rd_ext;
          end
        end else if (iss_r == cnt_r) begin
          div_start = 1'b1;
          neg_nxt   = sum_r[SW-1];
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          avg_nxt   = neg_r ? VW'(-div_quo[VW-1:0]) : div_quo[VW-1:0];
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = OUT_DW'({avg_r, min_r, max_r, cnt_r});
          out_tuser_nxt = st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `DMMA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH))
  `DMMA_ASSERT_IMP(a_full_cnt, out_valid_r && out_tuser_r == ST_FULL, out_tdata_r[CW-1:0] == CW'(DEPTH))
  `DMMA_ASSERT_NXT(a_query_scan, in_acc && act == ACT_QUERY && cnt_r != '0, state_r == S_SCAN)
  `DMMA_ASSERT_IMP(a_div_state, div_done, state_r == S_DIV)

endmodule
`default_nettype wire

FILE: sv/dmma_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module dmma_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/dmma_div.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module dmma_div #(
  parameter int N = 39,
  parameter int D = 7,
  localparam int SW = $clog2(N + 1)
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [D-1:0] divisor,
  output logic              done,
  output logic      [N-1:0] quotient
);

  logic [N-1:0]  quo_r;
  logic [D-1:0]  rem_r;
  logic [D-1:0]  dvs_r;
  logic [SW-1:0] step_r;
  logic          busy_r;
  logic          done_r;
  logic [D:0]    trial;
  logic          fits;

  assign trial = {rem_r, quo_r[N-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(N);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[N-2:0], fits};
      rem_r <= fits ? D'(trial - {1'b0, dvs_r}) : trial[D-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire
